FILE: rtl/oaht_pkg.sv
package oaht_pkg;

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 64;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 4;
   localparam int MARK_W   = 2;
   localparam int PROBE_STEP_SHIFT = 5;
   localparam int MIN_SIZE_SHIFT   = 2;
   localparam int PROBE_SLACK      = 16;

   localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ACCUMULATE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DELETE     = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_NEW      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_CHANGED  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_DELETED  = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd5;

   typedef enum logic [MARK_W-1:0] {
      MARK_UNUSED = 2'd0,
      MARK_USED   = 2'd1,
      MARK_TOMB   = 2'd2
   } mark_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_PROBE,
      FSM_COMMIT,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value_out;
      logic [COUNT_W-1:0]  element_count;
   } rsp_type;

endpackage

FILE: rtl/oaht_slot_ram.sv
module oaht_slot_ram #(
   parameter int AW = 10,
   parameter int DW = 130
) (
   input  logic          clock,
   input  logic [AW-1:0] addr,
   input  logic          we,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/oaht_probe_ctrl.sv
module oaht_probe_ctrl import oaht_pkg::*; #(
   parameter int MAX_SIZE_SHIFT = 10,
   parameter int KEY_BITS       = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [CSR_W-1:0]              tbl_shift,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [FUNC_W-1:0]             req_func,
   input  logic [63:0]                   req_key,
   input  logic [VALUE_W-1:0]            req_value_in,
   output logic                          res_valid,
   input  logic                          res_ready,
   output rsp_type                       res,
   output logic [MAX_SIZE_SHIFT-1:0]     ram_addr,
   output logic                          ram_we,
   output logic [MARK_W+KEY_BITS+VALUE_W-1:0] ram_wdata,
   input  logic [MARK_W+KEY_BITS+VALUE_W-1:0] ram_rdata
);

   localparam int AW     = MAX_SIZE_SHIFT;
   localparam int SW     = $clog2(AW + 1);
   localparam int PW     = (KEY_BITS > AW) ? KEY_BITS : AW;
   localparam int STEP_W = $clog2((1 << AW) + PROBE_SLACK + 1);
   localparam int LW     = (AW + 1 > COUNT_W + 2) ? AW + 1 : COUNT_W + 2;

   fsm_type                fsm_ff, fsm_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]     val_ff, val_in;
   logic [PW-1:0]          perturb_ff, perturb_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   found_ff, found_in;
   logic                   have_spot_ff, have_spot_in;
   logic                   spot_tomb_ff, spot_tomb_in;
   logic [AW-1:0]          spot_ff, spot_in;
   logic [VALUE_W-1:0]     old_ff, old_in;
   logic [COUNT_W-1:0]     live_ff, live_in;
   logic [COUNT_W-1:0]     tomb_ff, tomb_in;
   rsp_type                res_ff, res_in;

   logic [SW-1:0]          eff_shift;
   logic [AW:0]            size_one;
   logic [AW-1:0]          mask;
   logic [STEP_W-1:0]      limit;
   logic [KEY_BITS-1:0]    key_req;
   logic [PW-1:0]          key_req_ext;
   mark_type               rd_mark;
   logic [KEY_BITS-1:0]    rd_key;
   logic [VALUE_W-1:0]     rd_val;
   logic                   rd_hit;
   logic                   rd_free;
   logic                   last_step;
   logic                   stop;
   logic [AW-1:0]          nxt_idx;
   logic [STEP_W-1:0]      nxt_step;
   logic [COUNT_W:0]       used_sum;
   logic [LW-1:0]          load;
   logic                   is_full;
   logic [VALUE_W-1:0]     sum_val;

   always_comb begin
      if ({1'b0, tbl_shift} < 5'(MIN_SIZE_SHIFT)) begin
         eff_shift = SW'(MIN_SIZE_SHIFT);
      end else if ({1'b0, tbl_shift} > 5'(AW)) begin
         eff_shift = SW'(AW);
      end else begin
         eff_shift = SW'(tbl_shift);
      end
   end

   assign size_one    = (AW + 1)'(1) << eff_shift;
   assign mask        = size_one[AW-1:0] - AW'(1);
   assign limit       = STEP_W'(size_one) + STEP_W'(PROBE_SLACK);
   assign key_req     = req_key[KEY_BITS-1:0];
   assign key_req_ext = PW'(key_req);

   assign rd_mark   = mark_type'(ram_rdata[MARK_W+KEY_BITS+VALUE_W-1 -: MARK_W]);
   assign rd_key    = ram_rdata[KEY_BITS+VALUE_W-1 -: KEY_BITS];
   assign rd_val    = ram_rdata[VALUE_W-1:0];
   assign rd_hit    = (rd_mark == MARK_USED) && (rd_key == key_ff);
   assign rd_free   = (rd_mark != MARK_USED);
   assign nxt_step  = step_ff + STEP_W'(1);
   assign last_step = (nxt_step == limit);
   assign stop      = rd_hit || (rd_mark == MARK_UNUSED) || last_step;
   assign nxt_idx   = (idx_ff + (idx_ff << 2) + AW'(1) + perturb_ff[AW-1:0]) & mask;

   assign used_sum = {1'b0, live_ff} + {1'b0, tomb_ff};
   assign load     = LW'(used_sum) + LW'(used_sum >> 1);
   assign is_full  = (load >= LW'(size_one));
   assign sum_val  = old_ff + val_ff;

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_CLEAR: begin
            if (clr_ff == {AW{1'b1}}) begin
               fsm_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_valid) begin
               fsm_in = (req_func > FUNC_DELETE) ? FSM_COMMIT : FSM_PROBE;
            end
         end
         FSM_PROBE: begin
            if (stop) begin
               fsm_in = FSM_COMMIT;
            end
         end
         FSM_COMMIT: begin
            fsm_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (res_ready) begin
               fsm_in = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = (fsm_ff != FSM_IDLE);
      res_valid    = (fsm_ff == FSM_DONE);
      ram_addr     = idx_ff;
      ram_we       = 1'b0;
      ram_wdata    = {MARK_USED, key_ff, val_ff};
      clr_in       = clr_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      perturb_in   = perturb_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      have_spot_in = have_spot_ff;
      spot_tomb_in = spot_tomb_ff;
      spot_in      = spot_ff;
      old_in       = old_ff;
      live_in      = live_ff;
      tomb_in      = tomb_ff;
      res_in       = res_ff;
      case (fsm_ff)
         FSM_CLEAR: begin
            ram_addr  = clr_ff;
            ram_we    = 1'b1;
            ram_wdata = {MARK_UNUSED, {KEY_BITS{1'b0}}, {VALUE_W{1'b0}}};
            clr_in    = clr_ff + AW'(1);
         end
         FSM_IDLE: begin
            ram_addr = key_req_ext[AW-1:0] & mask;
            if (req_valid) begin
               func_in      = req_func;
               key_in       = key_req;
               val_in       = req_value_in;
               perturb_in   = key_req_ext;
               idx_in       = key_req_ext[AW-1:0] & mask;
               step_in      = '0;
               found_in     = 1'b0;
               have_spot_in = 1'b0;
            end
         end
         FSM_PROBE: begin
            found_in = rd_hit;
            old_in   = rd_val;
            if (!have_spot_ff && rd_free) begin
               have_spot_in = 1'b1;
               spot_in      = idx_ff;
               spot_tomb_in = (rd_mark != MARK_UNUSED);
            end
            if (!stop) begin
               ram_addr   = nxt_idx;
               idx_in     = nxt_idx;
               perturb_in = perturb_ff >> PROBE_STEP_SHIFT;
               step_in    = nxt_step;
            end
         end
         FSM_COMMIT: begin
            res_in.status    = STAT_NOTFOUND;
            res_in.value_out = '0;
            case (func_ff)
               FUNC_INSERT,
               FUNC_ACCUMULATE,
               FUNC_UPDATE: begin
                  if (found_ff) begin
                     ram_addr = idx_ff;
                     ram_we   = 1'b1;
                     if (func_ff == FUNC_ACCUMULATE) begin
                        ram_wdata        = {MARK_USED, key_ff, sum_val};
                        res_in.value_out = sum_val;
                     end else begin
                        ram_wdata        = {MARK_USED, key_ff, val_ff};
                        res_in.value_out = val_ff;
                     end
                     res_in.status = STAT_CHANGED;
                  end else if (func_ff != FUNC_UPDATE) begin
                     if (!have_spot_ff || is_full) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        ram_addr  = spot_ff;
                        ram_we    = 1'b1;
                        ram_wdata = {MARK_USED, key_ff, val_ff};
                        if (spot_tomb_ff) begin
                           tomb_in = tomb_ff - COUNT_W'(1);
                        end
                        live_in          = live_ff + COUNT_W'(1);
                        res_in.value_out = val_ff;
                        res_in.status    = STAT_NEW;
                     end
                  end
               end
               FUNC_LOOKUP: begin
                  if (found_ff) begin
                     res_in.status    = STAT_FOUND;
                     res_in.value_out = old_ff;
                  end
               end
               FUNC_DELETE: begin
                  if (found_ff) begin
                     ram_addr      = idx_ff;
                     ram_we        = 1'b1;
                     ram_wdata     = {MARK_TOMB, key_ff, old_ff};
                     tomb_in       = tomb_ff + COUNT_W'(1);
                     live_in       = live_ff - COUNT_W'(1);
                     res_in.status = STAT_DELETED;
                  end
               end
               default: begin
                  res_in.status = STAT_NOTFOUND;
               end
            endcase
            res_in.element_count = live_in;
         end
         FSM_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff  <= FSM_CLEAR;
         clr_ff  <= '0;
         live_ff <= '0;
         tomb_ff <= '0;
      end else begin
         fsm_ff  <= fsm_in;
         clr_ff  <= clr_in;
         live_ff <= live_in;
         tomb_ff <= tomb_in;
      end
      func_ff      <= func_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      perturb_ff   <= perturb_in;
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      found_ff     <= found_in;
      have_spot_ff <= have_spot_in;
      spot_tomb_ff <= spot_tomb_in;
      spot_ff      <= spot_in;
      old_ff       <= old_in;
      res_ff       <= res_in;
   end

   assign res = res_ff;

endmodule

FILE: rtl/open_address_hash_table_top.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_func, req_key, req_value_in
// rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_value_out, rsp_element_count
// csr_      in         csr_wr_en            csr_wr_data (table_size_shift)
//
// One transaction at a time: accept, a probe of each slot in turn (skipped for unknown
// functions), commit, handoff.
// The result goes from the core's result register to the output register at handoff,
// and the next transaction is taken only after the previous one is handed off.
// The single-port slot RAM (one read per cycle, registered read data) sets the probe rate.
// After reset a clearing pass marks all 2**MAX_SIZE_SHIFT slots unused, one per cycle;
// req_stall is high during it. A held response (rsp_stall high) keeps the core in handoff.
module open_address_hash_table_top import oaht_pkg::*; #(
   parameter int MAX_SIZE_SHIFT = 10,
   parameter int KEY_BITS       = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [63:0]         req_key,
   input  logic [VALUE_W-1:0]  req_value_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_value_out,
   output logic [COUNT_W-1:0]  rsp_element_count
);

   localparam int AW = MAX_SIZE_SHIFT;
   localparam int DW = MARK_W + KEY_BITS + VALUE_W;

   logic [CSR_W-1:0] shift_ff, shift_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             res_valid;
   logic             res_ready;
   rsp_type          res;
   logic [AW-1:0]    ram_addr;
   logic             ram_we;
   logic [DW-1:0]    ram_wdata;
   logic [DW-1:0]    ram_rdata;

   assign shift_in  = csr_wr_en ? csr_wr_data : shift_ff;
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= CSR_W'(10);
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   oaht_probe_ctrl #(
      .MAX_SIZE_SHIFT (MAX_SIZE_SHIFT),
      .KEY_BITS       (KEY_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .tbl_shift    (shift_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_key      (req_key),
      .req_value_in (req_value_in),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .ram_addr     (ram_addr),
      .ram_we       (ram_we),
      .ram_wdata    (ram_wdata),
      .ram_rdata    (ram_rdata)
   );

   oaht_slot_ram #(
      .AW (AW),
      .DW (DW)
   ) u_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_value_out     = rsp_ff.value_out;
   assign rsp_element_count = rsp_ff.element_count;

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STAT_FULL)
      else $error("status code out of range");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NOTFOUND || rsp_status == STAT_FULL ||
      rsp_status == STAT_DELETED) |-> rsp_value_out == '0)
      else $error("nonzero value with absent key");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while one is in flight");

endmodule
